// File: hw/rtl/stsd_pkg.sv
// ----------------------------------------------------------------------------
// stsd_pkg
// Shared types and constants of the per-source sequence duplicate filter:
// transaction payloads, stored record layout and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package stsd_pkg;

  // Default sizes of the source table and of each source's sequence ring.
  localparam int MAX_ENTRIES_DEF   = 16;
  localparam int HISTORY_DEPTH_DEF = 8;

  // Ring word value that marks an invalidated history entry.
  localparam logic [15:0] SEQ_INVALID = 16'hFFFF;

  // Command codes of an input transaction.
  localparam logic [1:0] CMD_CHECK  = 2'd0;
  localparam logic [1:0] CMD_RECORD = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic        [1:0]  cmd;
    logic        [63:0] source_id;
    logic        [15:0] sequence_req;
    logic signed [15:0] signal_strength;
    logic signed [7:0]  noise_ratio;
    logic        [31:0] timestamp;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic               found;
    logic               added;
    logic               table_full;
    logic               duplicate;
    logic        [3:0]  slot;
    logic        [31:0] packet_total;
    logic signed [15:0] last_strength;
    logic signed [7:0]  last_noise_ratio;
    logic        [31:0] last_time;
    logic        [15:0] last_seq;
  } out_t;

  // Per-source stored values (the ring pointer is kept next to it in memory).
  typedef struct packed {
    logic        [31:0] packet_total;
    logic signed [15:0] strength;
    logic signed [7:0]  noise;
    logic        [31:0] time_ms;
    logic        [15:0] seq;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new transaction
    logic search;    // one step of the id table scan
    logic alloc;     // register the source in the next free slot
    logic miss;      // report an unknown source (or a full table)
    logic rec_rd;    // read the source's record
    logic rec_cap;   // capture the record read data
    logic hist_step; // one step of the history ring sweep
    logic hist_cmp;  // sweep compares instead of writing
    logic update;    // store the packet and push the sequence
    logic clr_wb;    // write back the record with a rewound ring pointer
    logic finish;    // register the result
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;        // command code of the held transaction
    logic       hit;       // scan matched the source id this cycle
    logic       miss;      // scan ended without a match
    logic       room;      // table has a free slot
    logic       hist_done; // ring sweep finished
  } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/source_table_sequence_dedup_core.sv
// ----------------------------------------------------------------------------
// source_table_sequence_dedup_core
// Per-source sequence duplicate filter: a table of sources keyed by a 64-bit
// id, each with a ring of recent sequence numbers and last-packet values.
//
//   Channel  Ports                      Transfer
//   input    start, busy, in_data       accepted when start && !busy
//   result   out_valid, out_data        one-cycle strobe, cannot be held off
//
// One transaction at a time. The id scan reads one table entry per cycle
// from the id memory; a hit then reads the source's record (ST_REC_RD,
// ST_REC_CAP). A check sweeps the history memory one word per cycle and
// then compares the last word; a clear or the zero fill of a new source
// writes every word of the source's ring. The result strobe rises in the
// first cycle in which busy is low. Reset empties the table at once; no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module source_table_sequence_dedup_core #(
  parameter int MAX_ENTRIES   = stsd_pkg::MAX_ENTRIES_DEF,
  parameter int HISTORY_DEPTH = stsd_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire stsd_pkg::in_t in_data,
  output logic               out_valid,
  output stsd_pkg::out_t     out_data
);

  stsd_pkg::ctl_t  ctl;
  stsd_pkg::stat_t stat;

  // Sequencing of one transaction.
  stsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Table storage and result assembly.
  stsd_datapath #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ctl      (ctl),
    .stat     (stat),
    .out_data (out_data)
  );

`ifndef ASSERT_OFF
  // A result is only shown once the transaction has left the engine.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted transaction makes the engine busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start");

  // A full table reports nothing else.
  a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.table_full) |-> (!out_data.found && !out_data.added))
    else $error("table full result with found or added set");

  // A newly added source cannot have been found.
  a_added_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.added) |-> !out_data.found)
    else $error("added and found both set");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/stsd_ram.sv
// ----------------------------------------------------------------------------
// stsd_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module stsd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/stsd_datapath.sv
// ----------------------------------------------------------------------------
// stsd_datapath
// Source table datapath: id, record and history memories, the scan and sweep
// counters, the source count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stsd_datapath #(
  parameter int MAX_ENTRIES   = stsd_pkg::MAX_ENTRIES_DEF,
  parameter int HISTORY_DEPTH = stsd_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire stsd_pkg::in_t  in_data,
  input  wire stsd_pkg::ctl_t ctl,
  output stsd_pkg::stat_t     stat,
  output stsd_pkg::out_t      out_data
);

  localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int COUNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int PTR_W      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int J_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int HIST_DEPTH = MAX_ENTRIES * HISTORY_DEPTH;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int REC_W      = $bits(stsd_pkg::rec_t);
  localparam int RECRAM_W   = PTR_W + REC_W;

  // Held transaction and per-transaction state.
  stsd_pkg::in_t   item_r;
  stsd_pkg::rec_t  rec_r;
  stsd_pkg::rec_t  rec_new;
  stsd_pkg::out_t  out_r;
  logic [PTR_W-1:0]   ptr_r;
  logic [PTR_W-1:0]   ptr_next;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] scan_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic [IDX_W-1:0]   slot_r;
  logic [J_W-1:0]     j_r;
  logic               pend_s_r;
  logic               pend_h_r;
  logic               found_r;
  logic               added_r;
  logic               full_r;
  logic               dup_r;

  // Memory ports.
  logic [63:0]         id_rdata;
  logic                id_re;
  logic                rec_we;
  logic [RECRAM_W-1:0] rec_wdata;
  logic [RECRAM_W-1:0] rec_rdata;
  logic                hist_we;
  logic                hist_re;
  logic [HIST_AW-1:0]  hist_base;
  logic [HIST_AW-1:0]  hist_waddr;
  logic [HIST_AW-1:0]  hist_raddr;
  logic [15:0]         hist_wdata;
  logic [15:0]         hist_rdata;
  logic [15:0]         fill_val;

  logic issue_ok;
  logic j_end;
  logic hit;

  // Scan and sweep conditions.
  assign issue_ok = (scan_r < count_r);
  assign j_end    = (j_r == J_W'(HISTORY_DEPTH));
  assign hit      = pend_s_r && (id_rdata == item_r.source_id);

  assign stat.op        = item_r.cmd;
  assign stat.hit       = hit;
  assign stat.miss      = !pend_s_r && !issue_ok;
  assign stat.room      = (count_r < COUNT_W'(MAX_ENTRIES));
  assign stat.hist_done = j_end && !pend_h_r;

  // History addressing: each source owns HISTORY_DEPTH consecutive words.
  assign hist_base  = HIST_AW'(slot_r) * HIST_AW'(HISTORY_DEPTH);
  assign hist_raddr = hist_base + HIST_AW'(j_r);
  assign fill_val   = (item_r.cmd == stsd_pkg::CMD_CLEAR) ? stsd_pkg::SEQ_INVALID : 16'h0000;

  // Record update for a stored packet.
  assign ptr_next = (ptr_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  always_comb begin
    rec_new              = rec_r;
    rec_new.packet_total = rec_r.packet_total + 32'd1;
    rec_new.strength     = item_r.signal_strength;
    rec_new.noise        = item_r.noise_ratio;
    rec_new.time_ms      = item_r.timestamp;
    rec_new.seq          = item_r.sequence_req;
  end

  // Memory port steering.
  assign id_re   = ctl.search && issue_ok;
  assign hist_re = ctl.hist_step && ctl.hist_cmp && !j_end;

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = hist_raddr;
    hist_wdata = fill_val;
    if (ctl.update) begin
      hist_we    = 1'b1;
      hist_waddr = hist_base + HIST_AW'(ptr_r);
      hist_wdata = item_r.sequence_req;
    end else if (ctl.hist_step && !ctl.hist_cmp && !j_end) begin
      hist_we = 1'b1;
    end
  end

  always_comb begin
    rec_we    = ctl.update || ctl.clr_wb;
    rec_wdata = ctl.update ? {ptr_next, rec_new} : {{PTR_W{1'b0}}, rec_r};
  end

  stsd_ram #(
    .WIDTH  (64),
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_id_ram (
    .clk   (clk),
    .we    (ctl.alloc),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (item_r.source_id),
    .re    (id_re),
    .raddr (scan_r[IDX_W-1:0]),
    .rdata (id_rdata)
  );

  stsd_ram #(
    .WIDTH  (RECRAM_W),
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (slot_r),
    .wdata (rec_wdata),
    .re    (ctl.rec_rd),
    .raddr (slot_r),
    .rdata (rec_rdata)
  );

  stsd_ram #(
    .WIDTH  (16),
    .DEPTH  (HIST_DEPTH),
    .ADDR_W (HIST_AW)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Control registers: source count, scan and sweep progress, flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      scan_r   <= '0;
      j_r      <= '0;
      pend_s_r <= 1'b0;
      pend_h_r <= 1'b0;
      found_r  <= 1'b0;
      added_r  <= 1'b0;
      full_r   <= 1'b0;
      dup_r    <= 1'b0;
    end else begin
      if (ctl.load) begin
        scan_r   <= '0;
        j_r      <= '0;
        pend_s_r <= 1'b0;
        pend_h_r <= 1'b0;
        found_r  <= 1'b0;
        added_r  <= 1'b0;
        full_r   <= 1'b0;
        dup_r    <= 1'b0;
      end else begin
        if (ctl.search) begin
          pend_s_r <= issue_ok;
          if (issue_ok) begin
            scan_r <= scan_r + 1'b1;
          end
          if (hit) begin
            found_r <= 1'b1;
          end
        end
        if (ctl.alloc) begin
          count_r <= count_r + 1'b1;
          added_r <= 1'b1;
        end
        if (ctl.miss) begin
          full_r <= (item_r.cmd == stsd_pkg::CMD_RECORD);
        end
        if (ctl.hist_step) begin
          pend_h_r <= ctl.hist_cmp && !j_end;
          if (!j_end) begin
            j_r <= j_r + 1'b1;
          end
        end
        // Compare the ring word read in the previous cycle.
        if (pend_h_r && (hist_rdata == item_r.sequence_req)) begin
          dup_r <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
    end
    if (ctl.search) begin
      cmp_idx_r <= scan_r[IDX_W-1:0];
      if (hit) begin
        slot_r <= cmp_idx_r;
      end
    end
    if (ctl.alloc) begin
      slot_r <= count_r[IDX_W-1:0];
      rec_r  <= '0;
      ptr_r  <= '0;
    end
    if (ctl.miss) begin
      slot_r <= '0;
      rec_r  <= '0;
    end
    if (ctl.rec_cap) begin
      {ptr_r, rec_r} <= rec_rdata;
    end
    if (ctl.update) begin
      rec_r <= rec_new;
      ptr_r <= ptr_next;
    end
    if (ctl.clr_wb) begin
      ptr_r <= '0;
    end
    if (ctl.finish) begin
      out_r.found            <= found_r;
      out_r.added            <= added_r;
      out_r.table_full       <= full_r;
      out_r.duplicate        <= dup_r;
      out_r.slot             <= 4'(slot_r);
      out_r.packet_total     <= rec_r.packet_total;
      out_r.last_strength    <= rec_r.strength;
      out_r.last_noise_ratio <= rec_r.noise;
      out_r.last_time        <= rec_r.time_ms;
      out_r.last_seq         <= rec_r.seq;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// File: hw/rtl/stsd_ctrl.sv
// ----------------------------------------------------------------------------
// stsd_ctrl
// Controller of the duplicate filter: sequences the id scan, the record
// read, the history sweep and the record update for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module stsd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire stsd_pkg::stat_t stat,
  output stsd_pkg::ctl_t       ctl,
  output logic                 busy,
  output logic                 out_valid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_REC_RD,
    ST_REC_CAP,
    ST_HIST,
    ST_UPDATE,
    ST_CLR_WB,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        ctl.search = 1'b1;
        if (stat.hit) begin
          state_nxt = ST_REC_RD;
        end else if (stat.miss) begin
          if (stat.op == stsd_pkg::CMD_RECORD && stat.room) begin
            ctl.alloc = 1'b1;
            state_nxt = ST_HIST;
          end else begin
            ctl.miss  = 1'b1;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_REC_RD: begin
        ctl.rec_rd = 1'b1;
        state_nxt  = ST_REC_CAP;
      end
      ST_REC_CAP: begin
        ctl.rec_cap = 1'b1;
        unique case (stat.op)
          stsd_pkg::CMD_CHECK:  state_nxt = ST_HIST;
          stsd_pkg::CMD_RECORD: state_nxt = ST_UPDATE;
          stsd_pkg::CMD_CLEAR:  state_nxt = ST_HIST;
          default:              state_nxt = ST_DONE;
        endcase
      end
      ST_HIST: begin
        // Compare for a check; fill with zeros or the invalid mark otherwise.
        ctl.hist_step = 1'b1;
        ctl.hist_cmp  = (stat.op == stsd_pkg::CMD_CHECK);
        if (stat.hist_done) begin
          ctl.hist_step = 1'b0;
          unique case (stat.op)
            stsd_pkg::CMD_RECORD: state_nxt = ST_UPDATE;
            stsd_pkg::CMD_CLEAR:  state_nxt = ST_CLR_WB;
            default:              state_nxt = ST_DONE;
          endcase
        end
      end
      ST_UPDATE: begin
        ctl.update = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_CLR_WB: begin
        ctl.clr_wb = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        ctl.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and the result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE);
    end
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-source sequence duplicate filter. A local
// copy of the source table predicts every report; directed cases cover the
// unknown source, field extremes, ring wrap, clear and the unused command,
// then bursty random packet flows fill the table to overflow.
// ----------------------------------------------------------------------------
module tb;

  localparam int          NUM_SLOTS    = stsd_pkg::MAX_ENTRIES_DEF;
  localparam int          RING_DEPTH   = stsd_pkg::HISTORY_DEPTH_DEF;
  localparam int          POOL_SIZE    = 20;
  localparam int          RANDOM_ITEMS = 520;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [1:0]  CMD_CHECK    = stsd_pkg::CMD_CHECK;
  localparam logic [1:0]  CMD_RECORD   = stsd_pkg::CMD_RECORD;
  localparam logic [1:0]  CMD_CLEAR    = stsd_pkg::CMD_CLEAR;
  localparam logic [1:0]  CMD_SPARE    = 2'd3;
  localparam logic [63:0] ID_ZERO      = 64'h0;
  localparam logic [63:0] ID_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

  logic           clk   = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  stsd_pkg::in_t  in_data = '0;
  logic           out_valid;
  stsd_pkg::out_t out_data;

  // Local copy of the source table.
  logic [63:0] src_id       [NUM_SLOTS];
  int          src_count = 0;
  logic [15:0] src_ring     [NUM_SLOTS][RING_DEPTH];
  int          src_ring_ptr [NUM_SLOTS];
  logic [31:0] src_packets  [NUM_SLOTS];
  logic [15:0] src_strength [NUM_SLOTS];
  logic [7:0]  src_noise    [NUM_SLOTS];
  logic [31:0] src_seen_ms  [NUM_SLOTS];
  logic [15:0] src_last_seq [NUM_SLOTS];

  logic [63:0]    id_pool [POOL_SIZE];
  stsd_pkg::out_t predicted_reports[$];
  int             mismatch_count = 0;
  int             cycle_count    = 0;

  source_table_sequence_dedup_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Slot of a registered source, or -1 when the id is unknown.
  function automatic int find_entry(logic [63:0] id);
    int hit;
    hit = -1;
    for (int i = src_count - 1; i >= 0; i--) begin
      if (src_id[i] == id) hit = i;
    end
    return hit;
  endfunction

  // Computes the report of one transaction and updates the local table.
  function automatic stsd_pkg::out_t predict_report(stsd_pkg::in_t req);
    stsd_pkg::out_t rpt;
    int             k;
    logic           known;
    rpt   = '0;
    k     = find_entry(req.source_id);
    known = (k >= 0);

    // A record of an unknown source registers it, unless the table is full.
    if (req.cmd == CMD_RECORD && !known) begin
      if (src_count >= NUM_SLOTS) begin
        rpt.table_full = 1'b1;
        return rpt;
      end
      k = src_count;
      src_id[k] = req.source_id;
      for (int j = 0; j < RING_DEPTH; j++) src_ring[k][j] = 16'h0;
      src_ring_ptr[k] = 0;
      src_packets[k]  = '0;
      src_strength[k] = '0;
      src_noise[k]    = '0;
      src_seen_ms[k]  = '0;
      src_last_seq[k] = '0;
      src_count++;
      rpt.added = 1'b1;
    end
    if (k < 0) return rpt;

    case (req.cmd)
      CMD_CHECK: begin
        for (int j = 0; j < RING_DEPTH; j++) begin
          if (src_ring[k][j] == req.sequence_req) rpt.duplicate = 1'b1;
        end
      end
      CMD_RECORD: begin
        src_seen_ms[k]  = req.timestamp;
        src_strength[k] = req.signal_strength;
        src_noise[k]    = req.noise_ratio;
        src_packets[k]  = src_packets[k] + 32'd1;
        src_last_seq[k] = req.sequence_req;
        src_ring[k][src_ring_ptr[k]] = req.sequence_req;
        src_ring_ptr[k] = (src_ring_ptr[k] + 1) % RING_DEPTH;
      end
      CMD_CLEAR: begin
        for (int j = 0; j < RING_DEPTH; j++) src_ring[k][j] = stsd_pkg::SEQ_INVALID;
        src_ring_ptr[k] = 0;
      end
      default: begin
        // The unused command only reports the source.
      end
    endcase

    rpt.found            = known;
    rpt.slot             = 4'(k);
    rpt.packet_total     = src_packets[k];
    rpt.last_strength    = src_strength[k];
    rpt.last_noise_ratio = src_noise[k];
    rpt.last_time        = src_seen_ms[k];
    rpt.last_seq         = src_last_seq[k];
    return rpt;
  endfunction

  function automatic stsd_pkg::in_t make_request(logic [1:0] cmd, logic [63:0] id,
                                                 logic [15:0] seq, logic [15:0] strength,
                                                 logic [7:0] noise, logic [31:0] ts);
    stsd_pkg::in_t req;
    req.cmd             = cmd;
    req.source_id       = id;
    req.sequence_req    = seq;
    req.signal_strength = strength;
    req.noise_ratio     = noise;
    req.timestamp       = ts;
    return req;
  endfunction

  // Random transaction, mostly aimed at pool sources and their recent sequences.
  function automatic stsd_pkg::in_t random_request();
    stsd_pkg::in_t req;
    int            pick;
    int            k;
    req.source_id = ($urandom_range(99) < 88) ? id_pool[$urandom_range(POOL_SIZE - 1)]
                                               : {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 48)      req.cmd = CMD_RECORD;
    else if (pick < 83) req.cmd = CMD_CHECK;
    else if (pick < 92) req.cmd = CMD_CLEAR;
    else                req.cmd = CMD_SPARE;
    k    = find_entry(req.source_id);
    pick = $urandom_range(99);
    if (k >= 0 && pick < 40)      req.sequence_req = src_ring[k][$urandom_range(RING_DEPTH - 1)];
    else if (k >= 0 && pick < 70) req.sequence_req = src_last_seq[k] + 16'd1;
    else if (pick < 78)           req.sequence_req = pick[0] ? 16'hFFFF : 16'h0000;
    else                          req.sequence_req = 16'($urandom);
    req.signal_strength = 16'($urandom);
    req.noise_ratio     = 8'($urandom);
    req.timestamp       = $urandom;
    return req;
  endfunction

  // Sends one transaction and records its prediction once the engine is no longer busy.
  task automatic issue_request(input stsd_pkg::in_t req);
    in_data <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted_reports.push_back(predict_report(req));
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_for_reports();
    start <= 1'b0;
    @(posedge clk);
    while (predicted_reports.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compares every report with the oldest prediction.
  always @(posedge clk) begin : report_checker
    stsd_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (predicted_reports.size() == 0) begin
        $error("report with no transaction pending: %p", out_data);
        mismatch_count++;
      end else begin
        want = predicted_reports.pop_front();
        check_field("found", want.found, out_data.found);
        check_field("added", want.added, out_data.added);
        check_field("table_full", want.table_full, out_data.table_full);
        check_field("duplicate", want.duplicate, out_data.duplicate);
        check_field("slot", want.slot, out_data.slot);
        check_field("packet_total", want.packet_total, out_data.packet_total);
        check_field("last_strength", want.last_strength, out_data.last_strength);
        check_field("last_noise_ratio", want.last_noise_ratio, out_data.last_noise_ratio);
        check_field("last_time", want.last_time, out_data.last_time);
        check_field("last_seq", want.last_seq, out_data.last_seq);
      end
    end
  end

  // Check, clear and the unused command on an empty table report nothing.
  task automatic test_unknown_source();
    issue_request(make_request(CMD_CHECK, ID_ONES, 16'hFFFF, 16'h7FFF, 8'h7F, 32'hFFFF_FFFF));
    issue_request(make_request(CMD_CLEAR, ID_ONES, 16'h0000, 16'h8000, 8'h80, 32'h0));
    issue_request(make_request(CMD_SPARE, ID_ZERO, 16'h1234, 16'h0001, 8'h01, 32'h1));
  endtask

  // Registers both extreme ids with extreme packet values.
  task automatic test_record_extremes();
    issue_request(make_request(CMD_RECORD, ID_ZERO, 16'h0000, 16'h8000, 8'h80, 32'h0));
    issue_request(make_request(CMD_RECORD, ID_ZERO, 16'hFFFF, 16'h7FFF, 8'h7F, 32'hFFFF_FFFF));
    issue_request(make_request(CMD_RECORD, ID_ONES, 16'h5A5A, 16'hFFFF, 8'hFF, 32'h8000_0000));
  endtask

  // Hits on a recorded value and on the zero fill, then a miss.
  task automatic test_duplicate_check();
    issue_request(make_request(CMD_CHECK, ID_ZERO, 16'hFFFF, 16'h0, 8'h0, 32'h0));
    issue_request(make_request(CMD_CHECK, ID_ZERO, 16'h0000, 16'h0, 8'h0, 32'h0));
    issue_request(make_request(CMD_CHECK, ID_ZERO, 16'h1234, 16'h0, 8'h0, 32'h0));
  endtask

  // The unused command never flags a duplicate, even for a stored sequence.
  task automatic test_spare_command();
    issue_request(make_request(CMD_SPARE, ID_ZERO, 16'hFFFF, 16'h0, 8'h0, 32'h0));
  endtask

  // After a clear only the invalid marker matches; the next record starts at
  // the head of the ring.
  task automatic test_clear_history();
    issue_request(make_request(CMD_CLEAR, ID_ZERO, 16'h0000, 16'h0, 8'h0, 32'h0));
    issue_request(make_request(CMD_CHECK, ID_ZERO, 16'h0000, 16'h0, 8'h0, 32'h0));
    issue_request(make_request(CMD_CHECK, ID_ZERO, 16'hFFFF, 16'h0, 8'h0, 32'h0));
    issue_request(make_request(CMD_RECORD, ID_ZERO, 16'h0000, 16'h1234, 8'h12, 32'h55AA));
  endtask

  // Nine records push the oldest sequence out of the ring.
  task automatic test_ring_wrap();
    for (int i = 0; i < RING_DEPTH + 1; i++) begin
      issue_request(make_request(CMD_RECORD, ID_ONES, 16'h1000 + 16'(i), 16'(i), 8'(i),
                                 32'(i)));
    end
    issue_request(make_request(CMD_CHECK, ID_ONES, 16'h1000, 16'h0, 8'h0, 32'h0));
    issue_request(make_request(CMD_CHECK, ID_ONES, 16'h1001, 16'h0, 8'h0, 32'h0));
  endtask

  // Bursty packet flows over a pool larger than the table, so that the table
  // fills and later registrations are refused.
  task automatic test_random_traffic();
    stsd_pkg::in_t req;
    int            sent;
    int            burst;
    int            gap;
    bit            drained;
    id_pool[0] = ID_ZERO;
    id_pool[1] = ID_ONES;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        req = random_request();
        issue_request(req);
        sent++;
        // A check is often followed by the record of the same packet.
        if (req.cmd == CMD_CHECK && $urandom_range(1) == 1) begin
          req.cmd       = CMD_RECORD;
          req.timestamp = $urandom;
          issue_request(req);
          sent++;
        end
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        wait_for_reports();
        drained = 1'b1;
      end else begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
        if (gap > 0) idle_cycles(gap);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_unknown_source();
    test_record_extremes();
    test_duplicate_check();
    test_spare_command();
    test_clear_history();
    test_ring_wrap();
    test_random_traffic();
    wait_for_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
